### rtl/lfr_pkg.sv
// Shared types and constants for the LRU frame replacer.
// Used by the channel interfaces, the controller, the datapath and the top level.
package lfr_pkg;

  localparam int FRAME_W    = 6;
  localparam int NUM_FRAMES = 2 ** FRAME_W;
  localparam int CNT_W      = FRAME_W + 1;
  localparam int KIND_W     = 2;
  localparam int CAP_W      = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  localparam logic [KIND_W-1:0] KIND_VICTIM = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PIN    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNPIN  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic read_head;
    logic read_frame;
    logic pop;
    logic take_victim;
    logic unlink;
    logic append;
    logic load_out;
  } lfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              held_hit;
    logic              list_empty;
    logic              need_drop;
    logic              out_free;
  } lfr_status_t;

endpackage

### rtl/lfr_channels.sv
// Valid/ready channel interfaces for requests, results and the capacity register.
// Widths come from lfr_pkg.
interface lfr_req_if;
  logic                        valid;
  logic                        ready;
  logic [lfr_pkg::KIND_W-1:0]  kind;
  logic [lfr_pkg::FRAME_W-1:0] frame;
  modport source (output valid, output kind, output frame, input ready);
  modport sink (input valid, input kind, input frame, output ready);
endinterface

interface lfr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        victim_found;
  logic [lfr_pkg::FRAME_W-1:0] victim_frame;
  logic [lfr_pkg::CNT_W-1:0]   held_count;
  modport source (output valid, output victim_found, output victim_frame,
                  output held_count, input ready);
  modport sink (input valid, input victim_found, input victim_frame,
                input held_count, output ready);
endinterface

interface lfr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lfr_pkg::CAP_W-1:0]  capacity;
  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

### rtl/lfr_ctrl.sv
// Controller state machine for the LRU frame replacer.
// Drives lfr_pkg::lfr_cmd_t to the datapath and reads lfr_pkg::lfr_status_t back.
module lfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lfr_pkg::lfr_status_t status,
  output lfr_pkg::lfr_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_POP      = 3'd2;
  localparam logic [2:0] S_UNLINK   = 3'd3;
  localparam logic [2:0] S_FINISH   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.kind)
          lfr_pkg::KIND_VICTIM: begin
            if (status.list_empty) begin
              state_next = S_FINISH;
            end else begin
              cmd.read_head = 1'b1;
              state_next    = S_POP;
            end
          end
          lfr_pkg::KIND_PIN: begin
            if (status.held_hit) begin
              cmd.read_frame = 1'b1;
              state_next     = S_UNLINK;
            end else begin
              state_next = S_FINISH;
            end
          end
          lfr_pkg::KIND_UNPIN: begin
            // Full list: drop the oldest frame first, then look again.
            if (status.held_hit) begin
              state_next = S_FINISH;
            end else if (status.need_drop) begin
              cmd.read_head = 1'b1;
              state_next    = S_POP;
            end else begin
              cmd.append = 1'b1;
              state_next = S_FINISH;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_POP: begin
        cmd.pop = 1'b1;
        if (status.kind == lfr_pkg::KIND_VICTIM) begin
          cmd.take_victim = 1'b1;
          state_next      = S_FINISH;
        end else begin
          state_next = S_DISPATCH;
        end
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/lfr_datapath.sv
// Datapath of the LRU frame replacer: doubly linked age list in two memories,
// held flags, head/tail/count, capacity register and result register. Uses lfr_pkg.
module lfr_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  lfr_pkg::lfr_cmd_t           cmd,
  output lfr_pkg::lfr_status_t        status,
  input  logic [lfr_pkg::KIND_W-1:0]  in_kind,
  input  logic [lfr_pkg::FRAME_W-1:0] in_frame,
  input  logic                        cfg_valid,
  input  logic [lfr_pkg::CAP_W-1:0]   cfg_capacity,
  input  logic                        rsp_ready,
  output logic                        rsp_valid,
  output logic                        rsp_found,
  output logic [lfr_pkg::FRAME_W-1:0] rsp_frame,
  output logic [lfr_pkg::CNT_W-1:0]   rsp_count
);

  // Links indexed by frame number; only links of held frames are ever read.
  logic [lfr_pkg::FRAME_W-1:0] next_mem [lfr_pkg::NUM_FRAMES];
  logic [lfr_pkg::FRAME_W-1:0] prev_mem [lfr_pkg::NUM_FRAMES];

  logic [lfr_pkg::NUM_FRAMES-1:0] held;
  logic [lfr_pkg::CNT_W-1:0]      count;
  logic [lfr_pkg::CAP_W-1:0]      capacity;
  logic [lfr_pkg::FRAME_W-1:0]    head;
  logic [lfr_pkg::FRAME_W-1:0]    tail;
  logic [lfr_pkg::KIND_W-1:0]     req_kind;
  logic [lfr_pkg::FRAME_W-1:0]    req_frame;
  logic                           found;
  logic [lfr_pkg::FRAME_W-1:0]    vframe;
  logic [lfr_pkg::FRAME_W-1:0]    rd_next;
  logic [lfr_pkg::FRAME_W-1:0]    rd_prev;

  logic                        list_empty;
  logic                        can_append;
  logic                        do_append;
  logic                        is_head;
  logic                        is_tail;
  logic [lfr_pkg::CAP_W-1:0]   cap_eff;
  logic                        rd_en;
  logic [lfr_pkg::FRAME_W-1:0] rd_addr;
  logic                        nxt_we;
  logic [lfr_pkg::FRAME_W-1:0] nxt_wa;
  logic [lfr_pkg::FRAME_W-1:0] nxt_wd;
  logic                        prv_we;
  logic [lfr_pkg::FRAME_W-1:0] prv_wa;
  logic [lfr_pkg::FRAME_W-1:0] prv_wd;

  assign list_empty = (count == '0);
  assign can_append = (count < lfr_pkg::CNT_W'(lfr_pkg::NUM_FRAMES));
  assign do_append  = cmd.append && can_append;
  assign is_head    = (req_frame == head);
  assign is_tail    = (req_frame == tail);
  // A capacity of zero behaves as a capacity of one.
  assign cap_eff    = (capacity == '0) ? lfr_pkg::CAP_W'(1) : capacity;

  assign status.kind       = req_kind;
  assign status.held_hit   = held[req_frame];
  assign status.list_empty = list_empty;
  assign status.need_drop  = !list_empty && (count >= cap_eff);
  assign status.out_free   = !rsp_valid || rsp_ready;

  assign rd_en   = cmd.read_head || cmd.read_frame;
  assign rd_addr = cmd.read_head ? head : req_frame;

  // Unlinking splices the neighbors together; appending links behind the tail.
  assign nxt_we = (cmd.unlink && !is_head) || (do_append && !list_empty);
  assign nxt_wa = cmd.unlink ? rd_prev : tail;
  assign nxt_wd = cmd.unlink ? rd_next : req_frame;
  assign prv_we = (cmd.unlink && !is_tail) || do_append;
  assign prv_wa = cmd.unlink ? rd_next : req_frame;
  assign prv_wd = cmd.unlink ? rd_prev : tail;

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      next_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prev_mem[prv_wa] <= prv_wd;
    end
    if (rd_en) begin
      rd_next <= next_mem[rd_addr];
      rd_prev <= prev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      count     <= '0;
      capacity  <= lfr_pkg::CAP_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_capacity;
      end
      if (cmd.pop) begin
        held[head] <= 1'b0;
        count      <= count - 1'b1;
      end
      if (cmd.unlink) begin
        held[req_frame] <= 1'b0;
        count           <= count - 1'b1;
      end
      if (do_append) begin
        held[req_frame] <= 1'b1;
        count           <= count + 1'b1;
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_kind  <= in_kind;
      req_frame <= in_frame;
      found     <= 1'b0;
      vframe    <= '0;
    end
    if (cmd.pop) begin
      head <= rd_next;
      if (cmd.take_victim) begin
        found  <= 1'b1;
        vframe <= head;
      end
    end
    if (cmd.unlink) begin
      if (is_head) begin
        head <= rd_next;
      end
      if (is_tail) begin
        tail <= rd_prev;
      end
    end
    if (do_append) begin
      if (list_empty) begin
        head <= req_frame;
      end
      tail <= req_frame;
    end
    if (cmd.load_out) begin
      rsp_found <= found;
      rsp_frame <= vframe;
      rsp_count <= count;
    end
  end

endmodule

### rtl/lru_frame_replacer_unit.sv
// Top level of the LRU frame replacer: controller plus datapath.
// Depends on lfr_pkg, the channel interfaces, lfr_ctrl and lfr_datapath.
//
// Usage:
//   req carries one request (kind: victim, pin or unpin; frame). rsp returns
//   exactly one result per request: victim_found, victim_frame and the
//   held_count after the request. cfg writes the capacity register; it is
//   always ready and should only be written while no request is in flight.
//   Frames are kept in a doubly linked list held in two link memories indexed
//   by frame number, with one read port each, so every list step costs a
//   registered memory read.
//   Each request moves from idle through dispatch to finish. A victim request
//   on a non-empty list passes through pop on the way, a pin of a held frame
//   through unlink, and an unpin of a new frame goes through pop and back to
//   dispatch for every oldest frame dropped. The result register is loaded
//   as the block leaves finish for idle, so the result can transfer at the
//   same edge as the next request.
//   One result register parts the channels: a new request is taken while the
//   previous result waits; a stalled receiver holds the block in its final
//   step until the register frees up.
//   Reset (rst, synchronous) empties the list, sets capacity to 64 and
//   drops any pending result.
module lru_frame_replacer_unit (
  input  logic    clk,
  input  logic    rst,
  lfr_req_if.sink   req,
  lfr_rsp_if.source rsp,
  lfr_cfg_if.sink   cfg
);

  lfr_pkg::lfr_cmd_t    cmd;
  lfr_pkg::lfr_status_t status;

  assign cfg.ready = 1'b1;

  lfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lfr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_kind      (req.kind),
    .in_frame     (req.frame),
    .cfg_valid    (cfg.valid),
    .cfg_capacity (cfg.capacity),
    .rsp_ready    (rsp.ready),
    .rsp_valid    (rsp.valid),
    .rsp_found    (rsp.victim_found),
    .rsp_frame    (rsp.victim_frame),
    .rsp_count    (rsp.held_count)
  );

endmodule

### rtl/lfr_checker.sv
// Port-level assertions for the LRU frame replacer, bound to the top level.
// Depends on lfr_pkg and lru_frame_replacer_unit.
module lfr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        victim_found,
  input logic [lfr_pkg::FRAME_W-1:0] victim_frame,
  input logic [lfr_pkg::CNT_W-1:0]   held_count
);

  // The list never holds more frames than exist.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (held_count <= lfr_pkg::CNT_W'(lfr_pkg::NUM_FRAMES)))
    else $error("held_count beyond the number of frames");

  // A result without a victim reports frame zero.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !victim_found) |-> (victim_frame == '0))
    else $error("victim_frame set without a victim");

  // A victim was removed, so the list cannot be full afterwards.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && victim_found) |-> (held_count < lfr_pkg::CNT_W'(lfr_pkg::NUM_FRAMES)))
    else $error("full list reported after a victim");

  // Requests are processed one at a time.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while another is in progress");

  // A stalled result holds still.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(victim_found)
      && $stable(victim_frame) && $stable(held_count)))
    else $error("result changed while stalled");

endmodule

bind lru_frame_replacer_unit lfr_checker u_lfr_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .victim_found (rsp.victim_found),
  .victim_frame (rsp.victim_frame),
  .held_count   (rsp.held_count)
);
